// ===== sv/hpp_pkg.sv =====
// hpp_pkg: shared types and constants for the hypergraph weight propagation core
// no dependencies; imported by every module of the block
package hpp_pkg;

	// field widths fixed by the interface
	localparam int OP_W     = 2;
	localparam int TYPE_W   = 6;
	localparam int ARITY_W  = 2;
	localparam int WGT_W    = 16;
	localparam int OB_W     = 11;
	localparam int PASS_W   = 8;
	localparam int STAT_W   = 2;
	localparam int REL_W    = 16;
	localparam int PROD_W   = 2 * WGT_W;
	localparam int CIDX_W   = 2;

	// packed segment word: type, left argument, right argument
	localparam int SEG_W = TYPE_W + 2 * OB_W;

	// 1.0 in UQ1.15
	localparam logic [WGT_W-1:0] ONE_Q15 = 16'h8000;

	// item operations
	typedef enum logic [OP_W-1:0] {
		OP_LOAD_TYPE = 2'd0,
		OP_LOAD_SEG  = 2'd1,
		OP_RUN       = 2'd2,
		OP_READ      = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_ORDER     = 2'd2,
		ST_PASS_LIM  = 2'd3
	} status_t;

	// configuration register indexes
	typedef enum logic [CIDX_W-1:0] {
		CFG_OB_COUNT   = 2'd0,
		CFG_MODE       = 2'd1,
		CFG_RELTOL     = 2'd2,
		CFG_MAX_PASSES = 2'd3
	} cfg_idx_t;

	// arity codes
	typedef enum logic [ARITY_W-1:0] {
		AR_NULL   = 2'd0,
		AR_UNARY  = 2'd1,
		AR_BINARY = 2'd2,
		AR_NONE   = 2'd3
	} arity_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_RD,
		S_OB,
		S_OBW,
		S_SEG,
		S_ARG,
		S_MUL1,
		S_MUL2,
		S_ACC,
		S_CHK,
		S_WR,
		S_PEND,
		S_DONE
	} state_t;

	// accumulate unit request
	typedef struct packed {
		logic             max_mode;
		logic [WGT_W-1:0] acc;
		logic [WGT_W-1:0] term;
	} acc_req_t;

	// accumulate unit response
	typedef struct packed {
		logic [WGT_W-1:0] acc;
		logic             improved;
	} acc_rsp_t;

endpackage

// ===== sv/hpp_mul.sv =====
// hpp_mul: shared 16x16 unsigned multiplier with registered product
// depends on hpp_pkg
module hpp_mul
	import hpp_pkg::*;
(
	input  logic              clk,
	input  logic [WGT_W-1:0]  op_a,
	input  logic [WGT_W-1:0]  op_b,
	output logic [PROD_W-1:0] prod_s1
);

	// one product per cycle, registered so the result appears in the next cycle
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(op_a) * PROD_W'(op_b);
	end

endmodule

// ===== sv/hpp_acc.sv =====
// hpp_acc: weight accumulate unit, saturating sum or running maximum
// depends on hpp_pkg
module hpp_acc
	import hpp_pkg::*;
(
	input  acc_req_t req,
	output acc_rsp_t rsp
);

	logic [WGT_W:0] sum;

	assign sum = {1'b0, req.acc} + {1'b0, req.term};

	// sum saturates at 1.0, max keeps the larger term
	always_comb begin
		if (req.max_mode) begin
			rsp.improved = req.term > req.acc;
			rsp.acc      = rsp.improved ? req.term : req.acc;
		end else begin
			rsp.improved = 1'b0;
			rsp.acc      = (sum > {1'b0, ONE_Q15}) ? ONE_Q15 : sum[WGT_W-1:0];
		end
	end

endmodule

// ===== sv/hypergraph_prob_propagation_core.sv =====
// hypergraph_prob_propagation_core: top level, memories and pass sequencer
// depends on hpp_pkg, hpp_mul, hpp_acc
//
// channel | signals                          | direction
// in      | in_valid/in_ready + item fields  | into block
// out     | out_valid/out_ready + result     | out of block
// cfg     | cfg_valid/cfg_ready, index, data | into block
//
// load and read words pass through the sequencer and return to idle; a run
// clears the ob memory, then in each pass reads each ob, takes its segments
// one at a time through the one shared multiplier, checks and writes the ob,
// and closes the pass.
// after reset a clearing pass over all MAX_OBS+1 entries empties the range
// and ob memories; no word is taken meanwhile. a finished word waits in the
// output register while the next word is accepted.
module hypergraph_prob_propagation_core
	import hpp_pkg::*;
#(
	parameter int MAX_OBS      = 1024,
	parameter int MAX_SEGMENTS = 4096,
	parameter int MAX_TYPES    = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     operation,
	input  logic [TYPE_W-1:0]   type_id,
	input  logic [ARITY_W-1:0]  type_arity,
	input  logic [WGT_W-1:0]    type_prob,
	input  logic [OB_W-1:0]     seg_value,
	input  logic [OB_W-1:0]     seg_arg_left,
	input  logic [OB_W-1:0]     seg_arg_right,
	input  logic [OB_W-1:0]     query_ob,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STAT_W-1:0]   status,
	output logic [PASS_W-1:0]   passes_used,
	output logic [WGT_W-1:0]    ob_weight,
	output logic [TYPE_W-1:0]   best_type,
	output logic [OB_W-1:0]     best_left,
	output logic [OB_W-1:0]     best_right,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [REL_W-1:0]    cfg_data
);

	localparam int OBW = $clog2(MAX_OBS + 1);
	localparam int SIW = $clog2(MAX_SEGMENTS);
	localparam int SCW = $clog2(MAX_SEGMENTS + 1);
	localparam int TW  = $clog2(MAX_TYPES);
	localparam int RNG_W = SIW + SCW;
	localparam int OBM_W = WGT_W + SEG_W;
	localparam int TM_W  = ARITY_W + WGT_W;

	// configuration registers
	logic [OB_W-1:0]   ob_count_q;
	logic              mode_q;
	logic [REL_W-1:0]  reltol_q;
	logic [PASS_W-1:0] max_passes_q;

	// memories
	logic [TM_W-1:0]  type_mem [MAX_TYPES];
	logic [SEG_W-1:0] seg_mem  [MAX_SEGMENTS];
	logic [RNG_W-1:0] rng_mem  [MAX_OBS + 1];
	logic [OBM_W-1:0] ob_mem   [MAX_OBS + 1];
	logic [TM_W-1:0]  type_rd_q;
	logic [SEG_W-1:0] seg_rd_q;
	logic [RNG_W-1:0] rng_rd_q;
	logic [OBM_W-1:0] oba_rd_q;
	logic [OBM_W-1:0] obb_rd_q;

	// sequencer state
	state_t            state_q, state_d;
	logic              clr_rng_q;
	logic [OBW-1:0]    idx_q;
	logic [OBW-1:0]    ob_q;
	logic [OBW-1:0]    cnt_q;
	logic [SIW-1:0]    seg_q;
	logic [SCW-1:0]    rem_q;
	logic [PASS_W-1:0] pass_q;
	logic [PASS_W-1:0] limit_q;
	logic              changed_q;
	logic [WGT_W-1:0]  acc_q;
	logic [WGT_W-1:0]  old_q;
	logic [SEG_W-1:0]  best_q;
	logic [WGT_W-1:0]  p_q;
	logic [ARITY_W-1:0] arity_q;
	logic [WGT_W-1:0]  wr_q;
	logic [WGT_W-1:0]  a_q;
	logic              qok_q;

	// segment loading state
	logic [SCW-1:0]    seg_cnt_q;
	logic [OB_W-1:0]   last_q;
	logic [SIW-1:0]    rbeg_q;
	logic [SCW-1:0]    rlen_q;

	// pending result
	logic [STAT_W-1:0] res_status_q;
	logic [PASS_W-1:0] res_passes_q;
	logic [WGT_W-1:0]  res_weight_q;
	logic [SEG_W-1:0]  res_best_q;
	logic              out_valid_q;

	// control decodes
	logic              accept;
	logic              out_free;
	logic              ob_we;
	logic [OBW-1:0]    ob_waddr;
	logic [OBM_W-1:0]  ob_wdata;
	logic              rng_clr_we;
	logic [OBW-1:0]    addr_a;
	logic [OBW-1:0]    addr_b;

	// arithmetic
	logic [WGT_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] prod_s1;
	logic [WGT_W-1:0]  prod_hi;
	logic [WGT_W-1:0]  wl;
	logic [WGT_W-1:0]  wr;
	logic [WGT_W-1:0]  term;
	acc_req_t          acc_req;
	acc_rsp_t          acc_rsp;
	logic              sum_rose;
	logic [PROD_W:0]   thresh;

	// load decodes
	logic              type_bad;
	logic              seg_full;
	logic              seg_order;
	logic              seg_ok;
	logic [SEG_W-1:0]  seg_left_w;

	// segment word fields
	logic [TYPE_W-1:0] sr_type;
	logic [OB_W-1:0]   sr_left;
	logic [OB_W-1:0]   sr_right;
	logic              left_ok, right_ok;

	assign sr_type  = seg_rd_q[SEG_W-1 -: TYPE_W];
	assign sr_left  = seg_rd_q[2*OB_W-1 -: OB_W];
	assign sr_right = seg_rd_q[OB_W-1:0];
	assign left_ok  = (sr_left != '0) && (32'(sr_left) <= 32'(MAX_OBS));
	assign right_ok = (sr_right != '0) && (32'(sr_right) <= 32'(MAX_OBS));

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign prod_hi  = prod_s1[WGT_W+14:15];

	assign type_bad  = 32'(type_id) >= 32'(MAX_TYPES);
	assign seg_full  = seg_cnt_q == SCW'(MAX_SEGMENTS);
	assign seg_order = (seg_value == '0) || (32'(seg_value) > 32'(MAX_OBS)) ||
		(seg_value < last_q);
	assign seg_ok    = !type_bad && !seg_full && !seg_order;
	assign seg_left_w = {type_id, seg_arg_left, seg_arg_right};

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_count_q   <= OB_W'(1);
			mode_q       <= 1'b0;
			reltol_q     <= REL_W'(6554);
			max_passes_q <= PASS_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_OB_COUNT:   ob_count_q   <= cfg_data[OB_W-1:0];
				CFG_MODE:       mode_q       <= cfg_data[0];
				CFG_RELTOL:     reltol_q     <= cfg_data;
				CFG_MAX_PASSES: max_passes_q <= cfg_data[PASS_W-1:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR: begin
				if (idx_q == OBW'(MAX_OBS)) begin
					if (clr_rng_q)
						state_d = S_IDLE;
					else if (cnt_q == '0)
						state_d = S_PEND;
					else
						state_d = S_OB;
				end
			end
			S_IDLE: begin
				if (accept) begin
					unique case (op_t'(operation))
						OP_RUN:  state_d = S_CLR;
						OP_READ: state_d = S_RD;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_RD:   state_d = S_DONE;
			S_OB:   state_d = S_OBW;
			S_OBW:  state_d = (rng_rd_q[SCW-1:0] == '0) ? S_CHK : S_SEG;
			S_SEG:  state_d = S_ARG;
			S_ARG:  state_d = S_MUL1;
			S_MUL1: state_d = S_MUL2;
			S_MUL2: state_d = S_ACC;
			S_ACC:  state_d = (rem_q == SCW'(1)) ? S_CHK : S_SEG;
			S_CHK:  state_d = S_WR;
			S_WR:   state_d = (ob_q == cnt_q) ? S_PEND : S_OB;
			S_PEND: state_d = (changed_q && (pass_q + PASS_W'(1) < limit_q)) ? S_OB : S_DONE;
			S_DONE: state_d = out_free ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
		if (state_q == S_PEND && state_d == S_OB && cnt_q == '0)
			state_d = S_DONE;
	end

	// control outputs
	always_comb begin
		in_ready   = state_q == S_IDLE;
		ob_we      = 1'b0;
		ob_waddr   = ob_q;
		ob_wdata   = {acc_q, best_q};
		rng_clr_we = 1'b0;
		addr_a     = ob_q;
		addr_b     = OBW'(sr_right);
		mul_a      = '0;
		mul_b      = '0;
		unique case (state_q)
			S_CLR: begin
				ob_we      = 1'b1;
				ob_waddr   = idx_q;
				ob_wdata   = '0;
				rng_clr_we = clr_rng_q;
			end
			S_IDLE: addr_a = OBW'(query_ob);
			S_ARG:  addr_a = OBW'(sr_left);
			S_MUL1: begin
				mul_a = type_rd_q[WGT_W-1:0];
				mul_b = wl;
			end
			S_MUL2: begin
				mul_a = prod_hi;
				mul_b = wr_q;
			end
			S_CHK: begin
				mul_a = old_q;
				mul_b = reltol_q;
			end
			S_WR: ob_we = 1'b1;
			default: ;
		endcase
	end

	// argument weights; in max mode the current ob reads its running best
	always_comb begin
		wl = '0;
		wr = '0;
		if (left_ok)
			wl = (mode_q && 32'(sr_left) == 32'(ob_q)) ? acc_q : oba_rd_q[OBM_W-1 -: WGT_W];
		if (right_ok)
			wr = (mode_q && 32'(sr_right) == 32'(ob_q)) ? acc_q : obb_rd_q[OBM_W-1 -: WGT_W];
	end

	// segment term by arity
	always_comb begin
		case (arity_t'(arity_q))
			AR_NULL:   term = p_q;
			AR_UNARY:  term = a_q;
			AR_BINARY: term = prod_hi;
			default:   term = '0;
		endcase
	end

	assign acc_req.max_mode = mode_q;
	assign acc_req.acc      = acc_q;
	assign acc_req.term     = term;

	// sum mode: new*65536 > old*65536 + old*reltol
	assign thresh   = {1'b0, old_q, 16'b0} + {1'b0, prod_s1};
	assign sum_rose = {1'b0, acc_q, 16'b0} > thresh;

	hpp_mul u_mul (
		.clk     (clk),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.prod_s1 (prod_s1)
	);

	hpp_acc u_acc (
		.req (acc_req),
		.rsp (acc_rsp)
	);

	// type memory
	always_ff @(posedge clk) begin
		if (accept && op_t'(operation) == OP_LOAD_TYPE && !type_bad)
			type_mem[TW'(type_id)] <= {type_arity,
				(type_prob > ONE_Q15) ? ONE_Q15 : type_prob};
		type_rd_q <= type_mem[TW'(sr_type)];
	end

	// segment memory
	always_ff @(posedge clk) begin
		if (accept && op_t'(operation) == OP_LOAD_SEG && seg_ok)
			seg_mem[seg_cnt_q[SIW-1:0]] <= seg_left_w;
		seg_rd_q <= seg_mem[seg_q];
	end

	// range memory, cleared after reset
	always_ff @(posedge clk) begin
		if (rng_clr_we)
			rng_mem[idx_q] <= '0;
		else if (accept && op_t'(operation) == OP_LOAD_SEG && seg_ok) begin
			if (seg_value != last_q)
				rng_mem[OBW'(seg_value)] <= {seg_cnt_q[SIW-1:0], SCW'(1)};
			else
				rng_mem[OBW'(seg_value)] <= {rbeg_q, rlen_q + SCW'(1)};
		end
		rng_rd_q <= rng_mem[ob_q];
	end

	// ob weight and best segment memory, two read ports
	always_ff @(posedge clk) begin
		if (ob_we)
			ob_mem[ob_waddr] <= ob_wdata;
		oba_rd_q <= ob_mem[addr_a];
		obb_rd_q <= ob_mem[addr_b];
	end

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_rng_q <= 1'b1;
			idx_q     <= '0;
			seg_cnt_q <= '0;
			last_q    <= '0;
			changed_q <= 1'b0;
			pass_q    <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_CLR: begin
					idx_q <= idx_q + OBW'(1);
					if (idx_q == OBW'(MAX_OBS))
						clr_rng_q <= 1'b0;
				end
				S_IDLE: begin
					if (accept && op_t'(operation) == OP_LOAD_SEG && seg_ok) begin
						last_q    <= seg_value;
						seg_cnt_q <= seg_cnt_q + SCW'(1);
					end
					if (accept && op_t'(operation) == OP_RUN) begin
						idx_q     <= '0;
						pass_q    <= '0;
						changed_q <= 1'b0;
					end
				end
				S_ACC: begin
					if (acc_rsp.improved)
						changed_q <= 1'b1;
				end
				S_WR: begin
					if (!mode_q && sum_rose)
						changed_q <= 1'b1;
				end
				S_PEND: begin
					pass_q    <= pass_q + PASS_W'(1);
					changed_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_CLR: begin
				if (idx_q == OBW'(MAX_OBS))
					ob_q <= OBW'(1);
			end
			S_IDLE: begin
				if (accept) begin
					res_passes_q <= '0;
					res_weight_q <= '0;
					res_best_q   <= '0;
					res_status_q <= ST_OK;
					qok_q <= (query_ob != '0) && (32'(query_ob) <= 32'(MAX_OBS));
					cnt_q <= (32'(ob_count_q) > 32'(MAX_OBS)) ? OBW'(MAX_OBS) :
						OBW'(ob_count_q);
					limit_q <= (max_passes_q == '0) ? PASS_W'(1) : max_passes_q;
					unique case (op_t'(operation))
						OP_LOAD_TYPE: if (type_bad) res_status_q <= ST_FULL;
						OP_LOAD_SEG: begin
							if (type_bad || seg_full)
								res_status_q <= ST_FULL;
							else if (seg_order)
								res_status_q <= ST_ORDER;
							else if (seg_value != last_q) begin
								rbeg_q <= seg_cnt_q[SIW-1:0];
								rlen_q <= SCW'(1);
							end else
								rlen_q <= rlen_q + SCW'(1);
						end
						default: ;
					endcase
				end
			end
			S_RD: begin
				if (qok_q) begin
					res_weight_q <= oba_rd_q[OBM_W-1 -: WGT_W];
					res_best_q   <= oba_rd_q[SEG_W-1:0];
				end
			end
			S_OBW: begin
				seg_q  <= rng_rd_q[RNG_W-1 -: SIW];
				rem_q  <= rng_rd_q[SCW-1:0];
				old_q  <= oba_rd_q[OBM_W-1 -: WGT_W];
				acc_q  <= mode_q ? oba_rd_q[OBM_W-1 -: WGT_W] : '0;
				best_q <= oba_rd_q[SEG_W-1:0];
			end
			S_MUL1: begin
				p_q     <= type_rd_q[WGT_W-1:0];
				arity_q <= type_rd_q[TM_W-1 -: ARITY_W];
				wr_q    <= wr;
			end
			S_MUL2: a_q <= prod_hi;
			S_ACC: begin
				acc_q <= acc_rsp.acc;
				if (acc_rsp.improved)
					best_q <= seg_rd_q;
				seg_q <= seg_q + SIW'(1);
				rem_q <= rem_q - SCW'(1);
			end
			S_WR: ob_q <= ob_q + OBW'(1);
			S_PEND: begin
				ob_q <= OBW'(1);
				res_passes_q <= pass_q + PASS_W'(1);
				res_status_q <= (changed_q && !(pass_q + PASS_W'(1) < limit_q)) ?
					ST_PASS_LIM : ST_OK;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == S_DONE && out_free)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			status      <= res_status_q;
			passes_used <= res_passes_q;
			ob_weight   <= res_weight_q;
			best_type   <= res_best_q[SEG_W-1 -: TYPE_W];
			best_left   <= res_best_q[2*OB_W-1 -: OB_W];
			best_right  <= res_best_q[OB_W-1:0];
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	// a segment step always has a segment left to take
	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEG |-> rem_q != '0)
		else $error("segment step with empty range");

	// an accepted word drops in_ready in the next cycle
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// the pass counter never runs past its limit
	a_pass_cap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PEND |-> pass_q < limit_q)
		else $error("pass count beyond limit");
`endif

endmodule

// ===== dv/hypergraph_prob_propagation_core_tb.sv =====
// hypergraph_prob_propagation_core_tb: self-checking testbench for the weight propagation core
// depends on hpp_pkg and hypergraph_prob_propagation_core; predicts each result word in place
`timescale 1ns / 1ps

module hypergraph_prob_propagation_core_tb;
	import hpp_pkg::*;

	localparam int N_OBS   = 1024;
	localparam int N_SEGS  = 4096;
	localparam int N_TYPES = 64;

	// one input word
	typedef struct {
		op_t              op;
		logic [5:0]       tid;
		logic [1:0]       ar;
		logic [15:0]      prob;
		logic [10:0]      val;
		logic [10:0]      al;
		logic [10:0]      arr;
		logic [10:0]      q;
	} item_t;

	// one result word
	typedef struct {
		logic [1:0]  st;
		logic [7:0]  passes;
		logic [15:0] wgt;
		logic [5:0]  btype;
		logic [10:0] bleft;
		logic [10:0] bright;
	} result_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready;
	logic [OP_W-1:0] operation;
	logic [TYPE_W-1:0] type_id;
	logic [ARITY_W-1:0] type_arity;
	logic [WGT_W-1:0] type_prob;
	logic [OB_W-1:0] seg_value, seg_arg_left, seg_arg_right, query_ob;
	logic out_valid, out_ready;
	logic [STAT_W-1:0] status;
	logic [PASS_W-1:0] passes_used;
	logic [WGT_W-1:0] ob_weight;
	logic [TYPE_W-1:0] best_type;
	logic [OB_W-1:0] best_left, best_right;
	logic cfg_valid, cfg_ready;
	logic [CIDX_W-1:0] cfg_index;
	logic [REL_W-1:0] cfg_data;

	hypergraph_prob_propagation_core dut (.*);

	// clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow of the block state
	logic [15:0] type_wgt[N_TYPES];
	logic [1:0]  type_ar[N_TYPES];
	logic [5:0]  seg_tid[N_SEGS];
	logic [10:0] seg_l[N_SEGS];
	logic [10:0] seg_r[N_SEGS];
	int unsigned rng_start[N_OBS+1];
	int unsigned rng_len[N_OBS+1];
	int unsigned seg_total;
	int unsigned last_val;
	int unsigned ob_wgt[N_OBS+1];
	logic [5:0]  ob_btype[N_OBS+1];
	logic [10:0] ob_bleft[N_OBS+1];
	logic [10:0] ob_bright[N_OBS+1];
	int unsigned reg_obs, reg_mode, reg_tol, reg_passes;

	result_t pending_results[$];
	int mismatches;
	int items_sent;
	bit gap_en, stall_en;
	int hold_cycles;
	logic [5:0] loaded_types[$];

	function automatic int unsigned arg_weight(logic [10:0] ob);
		if (ob == 0 || ob > N_OBS) return 0;
		return ob_wgt[ob];
	endfunction

	// weight contributed by one segment
	function automatic int unsigned seg_term(int unsigned s);
		longint unsigned p, a;
		p = type_wgt[seg_tid[s]];
		case (arity_t'(type_ar[seg_tid[s]]))
			AR_NULL: return 32'(p);
			AR_UNARY: return 32'((p * arg_weight(seg_l[s])) >> 15);
			AR_BINARY: begin
				a = (p * arg_weight(seg_l[s])) >> 15;
				return 32'((a * arg_weight(seg_r[s])) >> 15);
			end
			default: return 0;
		endcase
	endfunction

	// one in-place pass over obs 1..cnt, returns whether anything moved
	function automatic bit sweep_obs(int unsigned cnt);
		bit moved;
		int unsigned sum, prev, w, s;
		moved = 0;
		for (int unsigned ob = 1; ob <= cnt; ob++) begin
			if (reg_mode == 0) begin
				sum = 0;
				prev = ob_wgt[ob];
				for (int unsigned k = 0; k < rng_len[ob]; k++) begin
					sum += seg_term(rng_start[ob] + k);
					if (sum > 32768) sum = 32768;
				end
				if (longint'(sum) * 65536 > longint'(prev) * (65536 + reg_tol))
					moved = 1;
				ob_wgt[ob] = sum;
			end else begin
				for (int unsigned k = 0; k < rng_len[ob]; k++) begin
					s = rng_start[ob] + k;
					w = seg_term(s);
					if (w > ob_wgt[ob]) begin
						ob_wgt[ob] = w;
						ob_btype[ob] = seg_tid[s];
						ob_bleft[ob] = seg_l[s];
						ob_bright[ob] = seg_r[s];
						moved = 1;
					end
				end
			end
		end
		return moved;
	endfunction

	// expected result of one accepted word, updating the shadow state
	function automatic result_t propagate_item(item_t it);
		result_t r;
		int unsigned cnt, lim, np, s;
		bit moved;
		r = '{default: '0};
		case (it.op)
			OP_LOAD_TYPE: begin
				type_ar[it.tid] = it.ar;
				type_wgt[it.tid] = (it.prob > 16'h8000) ? 16'h8000 : it.prob;
			end
			OP_LOAD_SEG: begin
				if (seg_total >= N_SEGS)
					r.st = ST_FULL;
				else if (it.val == 0 || it.val > N_OBS || it.val < last_val)
					r.st = ST_ORDER;
				else begin
					s = seg_total;
					seg_tid[s] = it.tid;
					seg_l[s] = it.al;
					seg_r[s] = it.arr;
					if (it.val != last_val || rng_len[it.val] == 0) begin
						rng_start[it.val] = s;
						rng_len[it.val] = 0;
					end
					rng_len[it.val]++;
					last_val = 32'(it.val);
					seg_total = s + 1;
				end
			end
			OP_RUN: begin
				cnt = (reg_obs > N_OBS) ? N_OBS : reg_obs;
				lim = (reg_passes == 0) ? 1 : reg_passes;
				for (int i = 0; i <= N_OBS; i++) begin
					ob_wgt[i] = 0;
					ob_btype[i] = '0;
					ob_bleft[i] = '0;
					ob_bright[i] = '0;
				end
				moved = 1;
				np = 0;
				while (moved && np < lim) begin
					moved = sweep_obs(cnt);
					np++;
				end
				if (moved) r.st = ST_PASS_LIM;
				r.passes = 8'(np);
			end
			default: begin
				if (it.q != 0 && it.q <= N_OBS) begin
					r.wgt = 16'(ob_wgt[it.q]);
					r.btype = ob_btype[it.q];
					r.bleft = ob_bleft[it.q];
					r.bright = ob_bright[it.q];
				end
			end
		endcase
		return r;
	endfunction

	// compare each accepted result word with the oldest prediction
	always @(posedge clk) begin
		result_t e;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st || passes_used !== e.passes || ob_weight !== e.wgt ||
						best_type !== e.btype || best_left !== e.bleft ||
						best_right !== e.bright) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("bad word at %0t: exp st=%0d p=%0d w=%0d t=%0d l=%0d r=%0d",
							$realtime, e.st, e.passes, e.wgt, e.btype, e.bleft, e.bright);
						$display("  got st=%0d p=%0d w=%0d t=%0d l=%0d r=%0d",
							status, passes_used, ob_weight, best_type, best_left, best_right);
					end
				end
			end
		end
	end

	// receiver with random stalls and long hold-offs on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else if (stall_en && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// run limit
	initial begin
		#2000ms;
		$display("Mismatches found");
		$finish;
	end

	// offer one word and hold it until taken
	task automatic send_item(item_t it);
		result_t r;
		in_valid <= 1'b1;
		operation <= it.op;
		type_id <= it.tid;
		type_arity <= it.ar;
		type_prob <= it.prob;
		seg_value <= it.val;
		seg_arg_left <= it.al;
		seg_arg_right <= it.arr;
		query_ob <= it.q;
		do @(posedge clk); while (!in_ready);
		r = propagate_item(it);
		pending_results.insert(pending_results.size(), r);
		items_sent++;
		if (gap_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic wait_results;
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int unsigned data);
		wait_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= REL_W'(data);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_OB_COUNT: reg_obs = data & 11'h7FF;
			CFG_MODE: reg_mode = data & 1;
			CFG_RELTOL: reg_tol = data & 16'hFFFF;
			default: reg_passes = data & 8'hFF;
		endcase
	endtask

	task automatic set_regs(int unsigned obs, int unsigned md, int unsigned tol, int unsigned np);
		write_reg(CFG_OB_COUNT, obs);
		write_reg(CFG_MODE, md);
		write_reg(CFG_RELTOL, tol);
		write_reg(CFG_MAX_PASSES, np);
	endtask

	// every field random, callers fix what matters
	function automatic item_t rand_item(op_t op);
		item_t it;
		it.op = op;
		it.tid = 6'($urandom);
		it.ar = 2'($urandom);
		it.prob = 16'($urandom);
		it.val = 11'($urandom);
		it.al = 11'($urandom);
		it.arr = 11'($urandom);
		it.q = 11'($urandom);
		return it;
	endfunction

	task automatic load_type(logic [5:0] tid, arity_t ar, logic [15:0] prob);
		item_t it;
		it = rand_item(OP_LOAD_TYPE);
		it.tid = tid;
		it.ar = ar;
		it.prob = prob;
		loaded_types.insert(loaded_types.size(), tid);
		send_item(it);
	endtask

	task automatic load_seg(logic [10:0] val, logic [10:0] al, logic [10:0] arr);
		item_t it;
		it = rand_item(OP_LOAD_SEG);
		it.tid = loaded_types[$urandom_range(0, loaded_types.size() - 1)];
		it.val = val;
		it.al = al;
		it.arr = arr;
		send_item(it);
	endtask

	task automatic read_ob(logic [10:0] q);
		item_t it;
		it = rand_item(OP_READ);
		it.q = q;
		send_item(it);
	endtask

	task automatic run_once;
		send_item(rand_item(OP_RUN));
	endtask

	// types of every arity, weight above one, ids at both ends
	task automatic test_types;
		load_type(6'd0, AR_NULL, 16'h4000);
		load_type(6'd63, AR_UNARY, 16'hFFFF);
		load_type(6'd1, AR_BINARY, 16'h8000);
		load_type(6'd2, AR_NONE, 16'h7FFF);
		load_type(6'd3, AR_NULL, 16'h0000);
		load_type(6'd4, AR_UNARY, 16'h8001);
	endtask

	// rejected values, zero and out of range arguments, several per ob
	task automatic test_segments;
		load_seg(11'd0, 11'd1, 11'd1);
		load_seg(11'd2047, 11'd1, 11'd1);
		load_seg(11'd1, 11'd0, 11'd0);
		load_seg(11'd1, 11'd2047, 11'd1025);
		load_seg(11'd2, 11'd1, 11'd1);
		load_seg(11'd2, 11'd2, 11'd1);
		load_seg(11'd3, 11'd2, 11'd1024);
		load_seg(11'd1, 11'd1, 11'd1);
	endtask

	// both modes, reads at the ob bounds
	task automatic test_modes;
		set_regs(4, 0, 0, 0);
		run_once();
		read_ob(11'd0);
		read_ob(11'd2);
		read_ob(11'd3);
		read_ob(11'd2047);
		set_regs(1024, 1, 65535, 255);
		run_once();
		read_ob(11'd1);
		read_ob(11'd3);
		read_ob(11'd1024);
		set_regs(2047, 0, 6554, 1);
		run_once();
		read_ob(11'd2);
	endtask

	// output held off long enough to fill the block, then a full drain
	task automatic test_backpressure;
		hold_cycles = 400;
		repeat (30) read_ob(11'($urandom_range(0, 8)));
		wait_results();
		repeat (5) read_ob(11'($urandom_range(0, 8)));
	endtask

	// random phases of register settings and mixed words
	task automatic test_random;
		int unsigned v, sel, hi;
		while (items_sent < 1150) begin
			hi = (last_val + 3 > 128) ? 128 : last_val + 3;
			sel = $urandom_range(0, 19);
			set_regs($urandom_range(1, hi), $urandom_range(0, 1),
				(sel == 0) ? 0 : (sel == 1) ? 65535 : $urandom_range(0, 65535),
				(sel == 2) ? 255 : (sel == 3) ? 0 : $urandom_range(1, 12));
			repeat (45) begin
				sel = $urandom_range(0, 99);
				if (sel < 8) begin
					load_type(6'($urandom), arity_t'($urandom_range(0, 3)),
						($urandom_range(0, 7) == 0) ? 16'($urandom)
							: 16'($urandom_range(0, 32768)));
				end else if (sel < 45 && seg_total < 600) begin
					if ($urandom_range(0, 11) == 0) begin
						v = ($urandom_range(0, 2) == 0) ? 0 :
							($urandom_range(0, 1) ? $urandom_range(1025, 2047)
								: $urandom_range(0, last_val));
					end else begin
						v = last_val + (($urandom_range(0, 2) == 0 && last_val < 120) ? 1 : 0);
						if (v == 0) v = 1;
					end
					load_seg(11'(v),
						($urandom_range(0, 15) == 0) ? 11'($urandom_range(0, 2047))
							: 11'($urandom_range(0, last_val + 3)),
						($urandom_range(0, 15) == 0) ? 11'($urandom_range(0, 2047))
							: 11'($urandom_range(0, last_val + 3)));
				end else if (sel < 55) begin
					run_once();
				end else begin
					read_ob(($urandom_range(0, 15) == 0) ? 11'($urandom_range(0, 2047))
						: 11'($urandom_range(0, last_val + 2)));
				end
			end
		end
	endtask

	// last stretch without idling: top ob, late low value, runs over every ob
	task automatic test_quiet_tail;
		gap_en = 0;
		stall_en = 0;
		wait_results();
		load_seg(11'd1024, 11'd1, 11'd2);
		load_seg(11'd5, 11'd1, 11'd2);
		set_regs(1024, 1, 0, 3);
		run_once();
		read_ob(11'd1024);
		read_ob(11'd1);
		set_regs(1024, 0, 0, 2);
		run_once();
		read_ob(11'd1024);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = '0;
		type_id = '0;
		type_arity = '0;
		type_prob = '0;
		seg_value = '0;
		seg_arg_left = '0;
		seg_arg_right = '0;
		query_ob = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		items_sent = 0;
		hold_cycles = 0;
		gap_en = 1;
		stall_en = 1;
		reg_obs = 1;
		reg_mode = 0;
		reg_tol = 6554;
		reg_passes = 64;
		seg_total = 0;
		last_val = 0;
		for (int i = 0; i < N_TYPES; i++) begin
			type_wgt[i] = '0;
			type_ar[i] = '0;
		end
		for (int i = 0; i <= N_OBS; i++) begin
			rng_start[i] = 0;
			rng_len[i] = 0;
			ob_wgt[i] = 0;
			ob_btype[i] = '0;
			ob_bleft[i] = '0;
			ob_bright[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_ob(11'd1);
		test_types();
		test_segments();
		test_modes();
		test_backpressure();
		test_random();
		test_quiet_tail();
		wait_results();
		repeat (50) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
